/* rtl/core/ti_pkg.sv */
// Shared types and constants of the tabulated integration block.
// Used by the channel interfaces and every module; depends on nothing.
`timescale 1ns / 1ps

package ti_pkg;

	localparam int SAMPLE_WIDTH = 32;
	localparam int COUNT_WIDTH  = 16;
	localparam int ACC_WIDTH    = 52;
	localparam int OUT_WIDTH    = 48;
	localparam int FRAC_BITS    = 16;
	localparam int STATUS_WIDTH = 2;

	localparam int SPAN_WIDTH = SAMPLE_WIDTH + 1;
	// |sum| <= 2^51 and |span| <= 2^32, so the product fits in this width
	localparam int PROD_WIDTH = ACC_WIDTH + SAMPLE_WIDTH;
	// divisor n * 3 * 2^16
	localparam int DIV_WIDTH  = COUNT_WIDTH + 2 + FRAC_BITS;

	localparam int MUL_STEPS  = SPAN_WIDTH;
	localparam int DIV_STEPS  = PROD_WIDTH;
	localparam int STEP_WIDTH = $clog2(DIV_STEPS + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [STATUS_WIDTH-1:0] {
		ST_OK            = 2'd0,
		ST_ODD_INTERVALS = 2'd1,
		ST_FEW_POINTS    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_FINISH
	} back_state_t;

	// one finished data set, handed from front to back
	typedef struct packed {
		logic signed [ACC_WIDTH-1:0]  sum;
		logic signed [SPAN_WIDTH-1:0] span;
		logic [COUNT_WIDTH-1:0]       count;
		logic                         mode;
		status_t                      status;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* rtl/core/ti_sample_if.sv */
// Input sample channel: valid/ready handshake with the sample payload.
// Depends on ti_pkg.
`timescale 1ns / 1ps

interface ti_sample_if;
	import ti_pkg::*;

	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_x;
	logic signed [SAMPLE_WIDTH-1:0] sample_y;
	logic                           last_point;

	modport source (output valid, output sample_x, output sample_y, output last_point,
		input ready);
	modport sink (input valid, input sample_x, input sample_y, input last_point,
		output ready);

endinterface

/* rtl/core/ti_result_if.sv */
// Result channel: valid/ready handshake with integral and status.
// Depends on ti_pkg.
`timescale 1ns / 1ps

interface ti_result_if;
	import ti_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [OUT_WIDTH-1:0] integral;
	logic [STATUS_WIDTH-1:0]     status;

	modport source (output valid, output integral, output status, input ready);
	modport sink (input valid, input integral, input status, output ready);

endinterface

/* rtl/core/ti_front.sv */
// Front end: takes samples, keeps the weighted sum, first abscissa and index,
// and on the last sample hands a job to the queue. Depends on ti_pkg, ti_sample_if.
`timescale 1ns / 1ps

module ti_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	ti_sample_if.sink         smp,
	input  ti_pkg::q_status_t q_stat,
	output logic              push,
	output ti_pkg::job_t      push_job
);
	import ti_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] IDX_MAX = '1;

	logic                           mode_q;
	logic [COUNT_WIDTH-1:0]         idx_q;
	logic signed [SAMPLE_WIDTH-1:0] first_q;
	logic signed [ACC_WIDTH-1:0]    sum_q;

	logic                        accept;
	logic signed [ACC_WIDTH:0]   y_ext;
	logic signed [ACC_WIDTH:0]   addend;
	logic signed [ACC_WIDTH-1:0] sum_mid;
	logic signed [ACC_WIDTH-1:0] sum_last;

	function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [ACC_WIDTH:0] s);
		if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
			return {s[ACC_WIDTH], {(ACC_WIDTH-1){~s[ACC_WIDTH]}}};
		return s[ACC_WIDTH-1:0];
	endfunction

	assign smp.ready = !q_stat.full;
	assign accept    = smp.valid && smp.ready;

	assign y_ext = {{(ACC_WIDTH+1-SAMPLE_WIDTH){smp.sample_y[SAMPLE_WIDTH-1]}}, smp.sample_y};

	// weight 1 for the first sample, 4 on odd Simpson indices, otherwise 2
	always_comb begin
		if (idx_q == '0)
			addend = y_ext;
		else if (mode_q && idx_q[0])
			addend = y_ext <<< 2;
		else
			addend = y_ext <<< 1;
	end

	assign sum_mid  = sat_acc({sum_q[ACC_WIDTH-1], sum_q} + addend);
	assign sum_last = sat_acc({sum_q[ACC_WIDTH-1], sum_q} + y_ext);

	assign push = accept && smp.last_point;

	always_comb begin
		push_job.sum   = sum_last;
		push_job.span  = SPAN_WIDTH'(smp.sample_x) - SPAN_WIDTH'(first_q);
		push_job.count = idx_q;
		push_job.mode  = mode_q;
		if (idx_q == '0)
			push_job.status = ST_FEW_POINTS;
		else if (mode_q && idx_q[0])
			push_job.status = ST_ODD_INTERVALS;
		else
			push_job.status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			idx_q   <= '0;
			first_q <= '0;
			sum_q   <= '0;
		end else begin
			if (cfg_wr_en)
				mode_q <= cfg_wr_data;
			if (accept) begin
				if (smp.last_point) begin
					idx_q   <= '0;
					first_q <= '0;
					sum_q   <= '0;
				end else begin
					if (idx_q == '0)
						first_q <= smp.sample_x;
					sum_q <= sum_mid;
					if (idx_q != IDX_MAX)
						idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/core/ti_queue.sv */
// Short job queue between front and back, register based.
// Depends on ti_pkg.
`timescale 1ns / 1ps

module ti_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ti_pkg::job_t      push_job,
	input  logic              pop,
	output ti_pkg::job_t      pop_job,
	output ti_pkg::q_status_t q_stat
);
	import ti_pkg::*;

	job_t                  slot_q [QUEUE_DEPTH];
	logic [QPTR_WIDTH-1:0] wr_ptr_q;
	logic [QPTR_WIDTH-1:0] rd_ptr_q;
	logic [QCNT_WIDTH-1:0] count_q;

	logic do_push;
	logic do_pop;

	function automatic logic [QPTR_WIDTH-1:0] next_ptr(input logic [QPTR_WIDTH-1:0] p);
		if (p == QPTR_WIDTH'(QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	assign q_stat.full  = (count_q == QCNT_WIDTH'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

	assign do_push = push && !q_stat.full;
	assign do_pop  = pop && !q_stat.empty;

	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/core/ti_back.sv */
// Back end: shift-add multiply of |sum| by |span|, restoring divide by n*D*2^16,
// rounding, saturation and the output register. Depends on ti_pkg, ti_result_if.
`timescale 1ns / 1ps

module ti_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ti_pkg::q_status_t q_stat,
	input  ti_pkg::job_t      pop_job,
	output logic              pop,
	ti_result_if.source       res
);
	import ti_pkg::*;

	localparam logic [PROD_WIDTH:0] POS_LIM = (PROD_WIDTH+1)'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
	localparam logic [PROD_WIDTH:0] NEG_LIM = (PROD_WIDTH+1)'(64'd1 << (OUT_WIDTH - 1));

	back_state_t state_q;
	back_state_t state_nxt;

	logic [STEP_WIDTH-1:0]   step_q;
	status_t                 status_q;
	logic                    neg_q;
	logic [ACC_WIDTH-1:0]    mcand_q;
	logic [SPAN_WIDTH-1:0]   mplier_q;
	logic [PROD_WIDTH-1:0]   prod_q;
	logic [DIV_WIDTH-1:0]    rem_q;
	logic [DIV_WIDTH-1:0]    div_q;

	logic                        out_valid_q;
	logic signed [OUT_WIDTH-1:0] out_integral_q;
	logic [STATUS_WIDTH-1:0]     out_status_q;

	logic do_mul;
	logic do_div;
	logic out_load;
	logic mul_last;
	logic div_last;

	logic [COUNT_WIDTH+1:0] count_x;
	logic [DIV_WIDTH:0]     trial;
	logic                   trial_ge;
	logic                   round_up;
	logic [PROD_WIDTH:0]    q_round;
	logic [PROD_WIDTH:0]    q_sat;
	logic signed [OUT_WIDTH-1:0] result_val;

	assign mul_last = (step_q == STEP_WIDTH'(MUL_STEPS - 1));
	assign div_last = (step_q == STEP_WIDTH'(DIV_STEPS - 1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty)
					state_nxt = (pop_job.status == ST_OK) ? BK_MUL : BK_FINISH;
			end
			BK_MUL: begin
				if (mul_last)
					state_nxt = BK_DIV;
			end
			BK_DIV: begin
				if (div_last)
					state_nxt = BK_FINISH;
			end
			BK_FINISH: begin
				if (!out_valid_q || res.ready)
					state_nxt = BK_IDLE;
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		do_mul   = 1'b0;
		do_div   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BK_IDLE:   pop = !q_stat.empty;
			BK_MUL:    do_mul = 1'b1;
			BK_DIV:    do_div = 1'b1;
			BK_FINISH: out_load = !out_valid_q || res.ready;
			default: begin
			end
		endcase
	end

	// n * 2 or n * 3
	always_comb begin
		if (pop_job.mode)
			count_x = {2'b00, pop_job.count} + {1'b0, pop_job.count, 1'b0};
		else
			count_x = {1'b0, pop_job.count, 1'b0};
	end

	assign trial    = {rem_q, prod_q[PROD_WIDTH-1]};
	assign trial_ge = (trial >= {1'b0, div_q});

	// ties away from zero on the magnitude
	assign round_up = ({rem_q, 1'b0} >= {1'b0, div_q});
	assign q_round  = {1'b0, prod_q} + (PROD_WIDTH+1)'(round_up);

	always_comb begin
		if (neg_q)
			q_sat = (q_round > NEG_LIM) ? NEG_LIM : q_round;
		else
			q_sat = (q_round > POS_LIM) ? POS_LIM : q_round;
		if (status_q != ST_OK)
			result_val = '0;
		else if (neg_q)
			result_val = -$signed(q_sat[OUT_WIDTH-1:0]);
		else
			result_val = $signed(q_sat[OUT_WIDTH-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= '0;
		else if (pop || (do_mul && mul_last) || (do_div && div_last))
			step_q <= '0;
		else if (do_mul || do_div)
			step_q <= step_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= pop_job.status;
			neg_q    <= pop_job.sum[ACC_WIDTH-1] ^ pop_job.span[SPAN_WIDTH-1];
			mcand_q  <= pop_job.sum[ACC_WIDTH-1] ? -pop_job.sum : pop_job.sum;
			mplier_q <= pop_job.span[SPAN_WIDTH-1] ? -pop_job.span : pop_job.span;
			prod_q   <= '0;
			rem_q    <= '0;
			div_q    <= {count_x, {FRAC_BITS{1'b0}}};
		end else if (do_mul) begin
			prod_q   <= {prod_q[PROD_WIDTH-2:0], 1'b0}
				+ (mplier_q[SPAN_WIDTH-1] ? PROD_WIDTH'(mcand_q) : '0);
			mplier_q <= {mplier_q[SPAN_WIDTH-2:0], 1'b0};
		end else if (do_div) begin
			rem_q  <= trial_ge ? DIV_WIDTH'(trial - {1'b0, div_q}) : trial[DIV_WIDTH-1:0];
			prod_q <= {prod_q[PROD_WIDTH-2:0], trial_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_integral_q <= result_val;
			out_status_q   <= status_q;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.integral = out_integral_q;
	assign res.status   = out_status_q;

endmodule

/* rtl/core/tabulated_integration.sv */
// Top level of the tabulated integration block: front, job queue and back.
// Depends on ti_pkg, ti_sample_if, ti_result_if, ti_front, ti_queue, ti_back.
`timescale 1ns / 1ps

// Integrates a stream of equally spaced Q16.16 samples with the composite
// trapezoidal (mode bit 0) or Simpson (mode bit 1) rule and returns one
// saturated Q32.16 result per data set, which ends on the sample flagged
// last_point. The front takes one sample per cycle while the two-entry job
// queue has room. The back scales each set: a load step, shift-add
// multiply, restoring divide (one quotient bit a cycle) and a finishing
// step; a set with an error status skips the multiply and divide. Sets
// that arrive faster than the back scales them fill the queue and hold off
// sample transfers until the back catches up. Results sit in an output
// register, so the back can scale the next set while one waits.
module tabulated_integration (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	ti_sample_if.sink   sample,
	ti_result_if.source result
);
	import ti_pkg::*;

	job_t      push_job;
	job_t      pop_job;
	logic      push;
	logic      pop;
	q_status_t q_stat;

	ti_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.smp         (sample),
		.q_stat      (q_stat),
		.push        (push),
		.push_job    (push_job)
	);

	ti_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_stat   (q_stat)
	);

	ti_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.pop_job (pop_job),
		.pop     (pop),
		.res     (result)
	);

`ifndef SYNTHESIS
	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("job queue reports full and empty together");

	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready && sample.last_point && q_stat.empty) |=> !q_stat.empty)
		else $error("last sample transfer did not reach the job queue");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status != ST_OK) |-> (result.integral == '0))
		else $error("error result carries a non-zero integral");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.status == ST_OK || result.status == ST_ODD_INTERVALS
			|| result.status == ST_FEW_POINTS))
		else $error("result status outside the defined codes");
`endif

endmodule
